// ===== design/nwsp_pkg.sv =====
// Shared types, constants and tables for the wind/temperature sentence parser.
`timescale 1ns / 1ps
`default_nettype none

package nwsp_pkg;

    typedef enum logic [1:0] {
        KIND_UNKNOWN = 2'd0,
        KIND_WIND    = 2'd1,
        KIND_TEMP    = 2'd2
    } t_kind;

    // State of the field being closed, as the number parser sees it.
    typedef struct packed {
        logic        digit;
        logic        malformed;
        logic        negative;
        logic [1:0]  frac;
        logic [19:0] mag;
    } t_field_status;

    localparam logic [19:0] VALUE_LIMIT   = 20'd999999;
    localparam logic [2:0]  HEADER_LEN    = 3'd6;
    localparam logic [7:0]  DELIM_DEFAULT = 8'd44;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;

    function automatic logic [7:0] wind_char(input logic [2:0] pos);
        case (pos)
            3'd0:    wind_char = 8'h24; // $
            3'd1:    wind_char = 8'h49; // I
            3'd2:    wind_char = 8'h49; // I
            3'd3:    wind_char = 8'h4D; // M
            3'd4:    wind_char = 8'h57; // W
            3'd5:    wind_char = 8'h56; // V
            default: wind_char = 8'h00;
        endcase
    endfunction

    function automatic logic [7:0] temp_char(input logic [2:0] pos);
        case (pos)
            3'd0:    temp_char = 8'h24; // $
            3'd1:    temp_char = 8'h57; // W
            3'd2:    temp_char = 8'h49; // I
            3'd3:    temp_char = 8'h58; // X
            3'd4:    temp_char = 8'h44; // D
            3'd5:    temp_char = 8'h52; // R
            default: temp_char = 8'h00;
        endcase
    endfunction

    function automatic logic [9:0] pow10(input logic [1:0] k);
        unique case (k)
            2'd0: pow10 = 10'd1;
            2'd1: pow10 = 10'd10;
            2'd2: pow10 = 10'd100;
            2'd3: pow10 = 10'd1000;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== design/nwsp_header_match.sv =====
// Header matcher: compares the first six characters against both headers.
`timescale 1ns / 1ps
`default_nettype none

module nwsp_header_match (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_adv,
    input  wire logic [7:0]    i_char,
    input  wire logic          i_last,
    output nwsp_pkg::t_kind    o_kind
);
    import nwsp_pkg::*;

    logic [2:0] r_pos, n_pos;
    logic [1:0] r_cand, n_cand;
    t_kind      r_kind, n_kind;

    always_comb begin
        n_pos  = r_pos;
        n_cand = r_cand;
        n_kind = r_kind;
        if (r_pos < HEADER_LEN) begin
            n_cand = r_cand & {i_char == temp_char(r_pos), i_char == wind_char(r_pos)};
            n_pos  = r_pos + 3'd1;
            if (n_pos == HEADER_LEN) begin
                priority if (n_cand[0]) n_kind = KIND_WIND;
                else if (n_cand[1])     n_kind = KIND_TEMP;
                else                    n_kind = KIND_UNKNOWN;
            end
        end
    end

    // Kind after this character; unknown until the header is complete.
    assign o_kind = n_kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= 3'd0;
            r_cand <= 2'b11;
            r_kind <= KIND_UNKNOWN;
        end else if (i_adv) begin
            if (i_last) begin
                r_pos  <= 3'd0;
                r_cand <= 2'b11;
                r_kind <= KIND_UNKNOWN;
            end else begin
                r_pos  <= n_pos;
                r_cand <= n_cand;
                r_kind <= n_kind;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/nwsp_number_field.sv =====
// Decimal field parser: sign, digits, point and saturating magnitude.
`timescale 1ns / 1ps
`default_nettype none

module nwsp_number_field #(
    parameter int FRACTION_DIGITS = 2
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_adv,
    input  wire logic [7:0]            i_char,
    input  wire logic                  i_delim,
    input  wire logic                  i_last,
    output nwsp_pkg::t_field_status    o_field
);
    import nwsp_pkg::*;

    localparam logic [1:0] FRAC_MAX = 2'(FRACTION_DIGITS);

    logic [19:0] r_mag;
    logic [1:0]  r_frac;
    logic        r_neg, r_point, r_digit, r_nonempty, r_malformed;

    t_field_status cur, post;
    logic          n_point, n_nonempty;
    logic          is_digit;
    logic [3:0]    digit_val;
    logic [23:0]   pushed;
    logic          take_digit;

    assign is_digit  = (i_char >= CHAR_ZERO) && (i_char <= CHAR_NINE);
    assign digit_val = 4'(i_char - CHAR_ZERO);
    assign pushed    = {1'b0, r_mag, 3'b000} + {3'b000, r_mag, 1'b0} + {20'd0, digit_val};
    assign take_digit = is_digit && (!r_point || (r_frac < FRAC_MAX));

    always_comb begin
        cur.digit     = r_digit;
        cur.malformed = r_malformed;
        cur.negative  = r_neg;
        cur.frac      = r_frac;
        cur.mag       = r_mag;

        post       = cur;
        n_point    = r_point;
        n_nonempty = 1'b1;
        priority if (is_digit) begin
            if (take_digit) begin
                post.mag = (pushed > {4'd0, VALUE_LIMIT}) ? VALUE_LIMIT : pushed[19:0];
                if (r_point) post.frac = r_frac + 2'd1;
            end
            post.digit = 1'b1;
        end else if (i_char == CHAR_POINT) begin
            if (r_point) post.malformed = 1'b1;
            n_point = 1'b1;
        end else if ((i_char == CHAR_MINUS || i_char == CHAR_PLUS) && !r_nonempty) begin
            post.negative = (i_char == CHAR_MINUS);
        end else begin
            post.malformed = 1'b1;
        end
    end

    // A delimiter closes the field as it stood before it.
    assign o_field = i_delim ? cur : post;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mag       <= 20'd0;
            r_frac      <= 2'd0;
            r_neg       <= 1'b0;
            r_point     <= 1'b0;
            r_digit     <= 1'b0;
            r_nonempty  <= 1'b0;
            r_malformed <= 1'b0;
        end else if (i_adv) begin
            if (i_delim || i_last) begin
                r_mag       <= 20'd0;
                r_frac      <= 2'd0;
                r_neg       <= 1'b0;
                r_point     <= 1'b0;
                r_digit     <= 1'b0;
                r_nonempty  <= 1'b0;
                r_malformed <= 1'b0;
            end else begin
                r_mag       <= post.mag;
                r_frac      <= post.frac;
                r_neg       <= post.negative;
                r_point     <= n_point;
                r_digit     <= post.digit;
                r_nonempty  <= n_nonempty;
                r_malformed <= post.malformed;
            end
        end
    end

endmodule

`default_nettype wire

// ===== design/nwsp_field_scale.sv =====
// Fixed-point conversion of a closed field: pad missing fraction digits, saturate, sign.
`timescale 1ns / 1ps
`default_nettype none

module nwsp_field_scale #(
    parameter int FRACTION_DIGITS = 2
) (
    input  nwsp_pkg::t_field_status i_field,
    output logic [20:0]             o_value
);
    import nwsp_pkg::*;

    localparam logic [1:0] FRAC_MAX = 2'(FRACTION_DIGITS);

    logic [1:0]  pad;
    logic [29:0] product;
    logic [19:0] mag_sat;

    assign pad     = FRAC_MAX - i_field.frac;
    assign product = 30'(i_field.mag) * 30'(pow10(pad));
    assign mag_sat = (product > 30'(VALUE_LIMIT)) ? VALUE_LIMIT : product[19:0];
    assign o_value = i_field.negative ? (21'd0 - {1'b0, mag_sat}) : {1'b0, mag_sat};

endmodule

`default_nettype wire

// ===== design/nmea_wind_sentence_parser_top.sv =====
// Top level of the wind/temperature sentence parser.
// A result is loaded from the input register into the result register when the final character advances.
// Throughput: one character per cycle; the input register and the result register
// overlap, and a final character waits only while the previous result is stalled.
// Reset (synchronous, active low) clears the parser state, the held values and
// restores the comma delimiter.
`timescale 1ns / 1ps
`default_nettype none

module nmea_wind_sentence_parser_top #(
    parameter int FRACTION_DIGITS = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,  // [7:0] char_code
    input  wire logic        i_s_axis_tlast,  // end_of_sentence
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    // [20:0] wind_direction, [41:21] wind_speed, [62:42] air_temperature, [63] field_error
    output logic [63:0]      o_m_axis_tdata,
    output logic [1:0]       o_m_axis_tuser,  // [1:0] sentence_kind
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_data       // field_delimiter
);
    import nwsp_pkg::*;

    typedef enum logic [1:0] {
        TGT_NONE  = 2'd0,
        TGT_DIR   = 2'd1,
        TGT_SPEED = 2'd2,
        TGT_TEMP  = 2'd3
    } t_target;

    function automatic t_target field_target(input t_kind kind, input logic [2:0] idx);
        field_target = TGT_NONE;
        if (kind == KIND_WIND && idx == 3'd1) field_target = TGT_DIR;
        if (kind == KIND_WIND && idx == 3'd3) field_target = TGT_SPEED;
        if (kind == KIND_TEMP && idx == 3'd2) field_target = TGT_TEMP;
    endfunction

    logic [7:0]  r_delim;
    logic        r_in_valid;
    logic [7:0]  r_in_char;
    logic        r_in_last;
    logic [2:0]  r_field_idx, n_field_idx;
    logic        r_err, n_err;
    logic [20:0] r_dir, n_dir, r_speed, n_speed, r_temp, n_temp;
    logic        r_out_valid;
    logic [63:0] r_out_data;
    logic [1:0]  r_out_kind;

    logic          adv, is_delim, closing, bad;
    t_kind         kind;
    t_field_status field;
    logic [20:0]   value;
    t_target       tgt_cur, tgt_next;

    assign adv      = r_in_valid && (!r_in_last || !r_out_valid || i_m_axis_tready);
    assign is_delim = (r_in_char == r_delim);
    assign closing  = is_delim || r_in_last;

    nwsp_header_match u_header (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_char  (r_in_char),
        .i_last  (r_in_last),
        .o_kind  (kind)
    );

    nwsp_number_field #(.FRACTION_DIGITS(FRACTION_DIGITS)) u_field (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_char  (r_in_char),
        .i_delim (is_delim),
        .i_last  (r_in_last),
        .o_field (field)
    );

    nwsp_field_scale #(.FRACTION_DIGITS(FRACTION_DIGITS)) u_scale (
        .i_field (field),
        .o_value (value)
    );

    always_comb begin
        n_field_idx = r_field_idx;
        if (is_delim && r_field_idx != 3'd7) n_field_idx = r_field_idx + 3'd1;
        tgt_cur  = field_target(kind, r_field_idx);
        tgt_next = field_target(kind, n_field_idx);
        bad      = field.malformed || !field.digit;

        n_err   = r_err;
        n_dir   = r_dir;
        n_speed = r_speed;
        n_temp  = r_temp;
        if (closing && tgt_cur != TGT_NONE) begin
            if (bad) begin
                n_err = 1'b1;
            end else begin
                unique case (tgt_cur)
                    TGT_NONE:  ;
                    TGT_DIR:   n_dir   = value;
                    TGT_SPEED: n_speed = value;
                    TGT_TEMP:  n_temp  = value;
                endcase
            end
        end
        // Ending on a delimiter leaves an empty field behind it.
        if (is_delim && r_in_last && tgt_next != TGT_NONE) n_err = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delim     <= DELIM_DEFAULT;
            r_in_valid  <= 1'b0;
            r_field_idx <= 3'd0;
            r_err       <= 1'b0;
            r_dir       <= 21'd0;
            r_speed     <= 21'd0;
            r_temp      <= 21'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) r_delim <= i_cfg_data;

            if (o_s_axis_tready) r_in_valid <= i_s_axis_tvalid;

            if (i_m_axis_tready) r_out_valid <= 1'b0;

            if (adv) begin
                r_dir   <= n_dir;
                r_speed <= n_speed;
                r_temp  <= n_temp;
                if (r_in_last) begin
                    r_field_idx <= 3'd0;
                    r_err       <= 1'b0;
                    r_out_valid <= 1'b1;
                end else begin
                    r_field_idx <= n_field_idx;
                    r_err       <= n_err;
                end
            end
        end
    end

    // Payload registers: no reset needed.
    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_char <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
        if (adv && r_in_last) begin
            r_out_data <= {n_err, n_temp, n_speed, n_dir};
            r_out_kind <= kind;
        end
    end

    assign o_s_axis_tready = !r_in_valid || adv;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_cfg_ready     = 1'b1;

endmodule

`default_nettype wire

// ===== design/nwsp_checker.sv =====
// Port-level checker for the sentence parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module nwsp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [63:0] o_m_axis_tdata,
    input wire logic [1:0]  o_m_axis_tuser
);

    // Hold a stalled result.
    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=> o_m_axis_tvalid)
        else $error("result valid dropped while stalled");

    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            ($stable(o_m_axis_tdata) && $stable(o_m_axis_tuser)))
        else $error("result payload changed while stalled");

    // No field is used in a sentence of unknown kind, so no error either.
    a_unknown_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser == 2'd0) |-> !o_m_axis_tdata[63])
        else $error("field error on a sentence of unknown kind");

    // Saturation keeps every held value within six integer-and-fraction digits.
    a_values_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ($signed(o_m_axis_tdata[20:0])  >= -21'sd999999 &&
             $signed(o_m_axis_tdata[20:0])  <=  21'sd999999 &&
             $signed(o_m_axis_tdata[41:21]) >= -21'sd999999 &&
             $signed(o_m_axis_tdata[41:21]) <=  21'sd999999 &&
             $signed(o_m_axis_tdata[62:42]) >= -21'sd999999 &&
             $signed(o_m_axis_tdata[62:42]) <=  21'sd999999))
        else $error("held value beyond saturation limit");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind nmea_wind_sentence_parser_top nwsp_checker u_nwsp_checker (.*);

`default_nettype wire
